[sv/assert_macros.svh]
// assertion macros shared by the cosine similarity rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at each rising edge, off during reset
`define CSIM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked at each rising edge, off during reset
`define CSIM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/csim_pkg.sv]
// shared types and constants of the cosine similarity unit
`timescale 1ns / 1ps

package csim_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    localparam int DOT_W  = 42;
    localparam int SQ_W   = 41;
    localparam int PROD_W = 2 * SQ_W;
    localparam int RAD_W  = 84;
    localparam int ROOT_W = 43;
    localparam int SREM_W = 45;
    localparam int DVD_W  = DOT_W + 14;
    localparam int DREM_W = ROOT_W;
    localparam int Q_W    = 15;

    localparam int ONE_Q14 = 16384;

    // iteration counts of the back-end phases
    localparam int MUL_STEPS  = SQ_W;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int DIV_STEPS  = DVD_W;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic acc;
        logic mul_init;
        logic mul_step;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

[sv/csim_ctrl.sv]
// controller state machine of the cosine similarity unit
`timescale 1ns / 1ps

module csim_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last_pair,
    output logic              s_ready,
    input  csim_pkg::stat_t   stat,
    output csim_pkg::cmd_t    cmd,
    output csim_pkg::state_t  state
);

    csim_pkg::state_t                 state_reg, state_next;
    logic [csim_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                             beat;

    assign state = state_reg;
    assign beat  = s_valid && s_ready;

    // state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csim_pkg::ST_ACC;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            csim_pkg::ST_ACC: begin
                if (beat && s_last_pair) begin
                    state_next = csim_pkg::ST_MUL;
                    step_next  = '0;
                end
            end
            csim_pkg::ST_MUL: begin
                if (step_reg == csim_pkg::STEP_W'(csim_pkg::MUL_STEPS)) begin
                    state_next = csim_pkg::ST_SQRT;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            csim_pkg::ST_SQRT: begin
                if (step_reg == csim_pkg::STEP_W'(csim_pkg::SQRT_STEPS)) begin
                    state_next = csim_pkg::ST_DIV;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            csim_pkg::ST_DIV: begin
                if (step_reg == csim_pkg::STEP_W'(csim_pkg::DIV_STEPS)) begin
                    state_next = csim_pkg::ST_OUT;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            csim_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    state_next = csim_pkg::ST_ACC;
                end
            end
            default: begin
                state_next = csim_pkg::ST_ACC;
                step_next  = '0;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            csim_pkg::ST_ACC: begin
                s_ready = 1'b1;
                cmd.acc = beat;
            end
            csim_pkg::ST_MUL: begin
                cmd.mul_init = (step_reg == '0);
                cmd.mul_step = (step_reg != '0);
            end
            csim_pkg::ST_SQRT: begin
                cmd.sqrt_init = (step_reg == '0);
                cmd.sqrt_step = (step_reg != '0);
            end
            csim_pkg::ST_DIV: begin
                cmd.div_init = (step_reg == '0);
                cmd.div_step = (step_reg != '0);
            end
            csim_pkg::ST_OUT: begin
                cmd.load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/csim_dp.sv]
// datapath of the cosine similarity unit: sums, multiply, root, divide
`timescale 1ns / 1ps

module csim_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic signed [15:0]   s_elem_a,
    input  logic signed [15:0]   s_elem_b,
    input  csim_pkg::cmd_t       cmd,
    output csim_pkg::stat_t      stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_cosine,
    output logic                 m_zero_norm,
    output logic                 m_too_long
);

    // accumulators
    logic signed [csim_pkg::DOT_W-1:0] dot_reg;
    logic [csim_pkg::SQ_W-1:0]         sqa_reg, sqb_reg;
    logic [csim_pkg::CNT_W-1:0]        cnt_reg;
    logic                              ovf_reg;

    // shift-add multiplier
    logic [csim_pkg::PROD_W-1:0] mcand_reg, prod_reg;
    logic [csim_pkg::SQ_W-1:0]   mplier_reg;

    // digit-by-digit square root
    logic [csim_pkg::RAD_W-1:0]  rad_reg;
    logic [csim_pkg::SREM_W-1:0] srem_reg;
    logic [csim_pkg::ROOT_W-1:0] root_reg;

    // restoring divider
    logic [csim_pkg::DVD_W-1:0]  dvd_reg;
    logic [csim_pkg::DREM_W-1:0] drem_reg;
    logic [csim_pkg::Q_W-1:0]    q_reg;
    logic                        big_reg;

    // output register
    logic                        m_valid_reg;
    logic signed [15:0]          cos_reg;
    logic                        zero_reg, long_reg;

    logic signed [31:0]                ab, aa, bb;
    logic signed [csim_pkg::DOT_W:0]   dsum;
    logic [csim_pkg::SQ_W:0]           asum, bsum;
    logic signed [csim_pkg::DOT_W-1:0] dot_next;
    logic [csim_pkg::SQ_W-1:0]         sqa_next, sqb_next;
    logic                              full;
    logic [csim_pkg::SREM_W-1:0]       st, strial;
    logic [csim_pkg::DREM_W:0]         dt;
    logic [csim_pkg::DOT_W-1:0]        mag;
    logic [csim_pkg::Q_W-1:0]          qmag;
    logic signed [15:0]                cos_val;
    logic                              zero_val;

    assign ab   = s_elem_a * s_elem_b;
    assign aa   = s_elem_a * s_elem_a;
    assign bb   = s_elem_b * s_elem_b;
    assign full = (cnt_reg == csim_pkg::CNT_W'(csim_pkg::MAX_ELEMENTS));

    // saturating sums
    always_comb begin
        dsum = (csim_pkg::DOT_W+1)'(dot_reg) + (csim_pkg::DOT_W+1)'(ab);
        asum = {1'b0, sqa_reg} + (csim_pkg::SQ_W+1)'(aa[30:0]);
        bsum = {1'b0, sqb_reg} + (csim_pkg::SQ_W+1)'(bb[30:0]);
        if (dsum[csim_pkg::DOT_W] != dsum[csim_pkg::DOT_W-1]) begin
            dot_next = dsum[csim_pkg::DOT_W]
                ? {1'b1, {(csim_pkg::DOT_W-1){1'b0}}}
                : {1'b0, {(csim_pkg::DOT_W-1){1'b1}}};
        end else begin
            dot_next = dsum[csim_pkg::DOT_W-1:0];
        end
        sqa_next = asum[csim_pkg::SQ_W] ? '1 : asum[csim_pkg::SQ_W-1:0];
        sqb_next = bsum[csim_pkg::SQ_W] ? '1 : bsum[csim_pkg::SQ_W-1:0];
    end

    // root and divide trial values
    always_comb begin
        st     = {srem_reg[csim_pkg::SREM_W-3:0], rad_reg[csim_pkg::RAD_W-1 -: 2]};
        strial = {root_reg[csim_pkg::SREM_W-3:0], 2'b01};
        dt     = {drem_reg, dvd_reg[csim_pkg::DVD_W-1]};
    end

    // final clamp and sign
    always_comb begin
        mag      = dot_reg[csim_pkg::DOT_W-1] ? csim_pkg::DOT_W'(-dot_reg)
                                              : csim_pkg::DOT_W'(dot_reg);
        zero_val = (sqa_reg == '0) || (sqb_reg == '0);
        if (big_reg || (q_reg > csim_pkg::Q_W'(csim_pkg::ONE_Q14))) begin
            qmag = csim_pkg::Q_W'(csim_pkg::ONE_Q14);
        end else begin
            qmag = q_reg;
        end
        if (zero_val) begin
            cos_val = '0;
        end else if (dot_reg[csim_pkg::DOT_W-1]) begin
            cos_val = -$signed({1'b0, qmag});
        end else begin
            cos_val = $signed({1'b0, qmag});
        end
    end

    // accumulator registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
            sqa_reg <= '0;
            sqb_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.load) begin
            dot_reg <= '0;
            sqa_reg <= '0;
            sqb_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.acc) begin
            if (full) begin
                ovf_reg <= 1'b1;
            end else begin
                dot_reg <= dot_next;
                sqa_reg <= sqa_next;
                sqb_reg <= sqb_next;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // back-end iteration registers
    always_ff @(posedge aclk) begin
        if (cmd.mul_init) begin
            mcand_reg  <= csim_pkg::PROD_W'(sqa_reg);
            mplier_reg <= sqb_reg;
            prod_reg   <= '0;
        end else if (cmd.mul_step) begin
            if (mplier_reg[0]) begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= csim_pkg::RAD_W'(prod_reg);
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= rad_reg << 2;
            if (st >= strial) begin
                srem_reg <= st - strial;
                root_reg <= {root_reg[csim_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                srem_reg <= st;
                root_reg <= {root_reg[csim_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.div_init) begin
            dvd_reg  <= {mag, 14'd0};
            drem_reg <= '0;
            q_reg    <= '0;
            big_reg  <= 1'b0;
        end else if (cmd.div_step) begin
            dvd_reg <= dvd_reg << 1;
            big_reg <= big_reg | q_reg[csim_pkg::Q_W-1];
            if (dt >= {1'b0, root_reg}) begin
                drem_reg <= csim_pkg::DREM_W'(dt - {1'b0, root_reg});
                q_reg    <= {q_reg[csim_pkg::Q_W-2:0], 1'b1};
            end else begin
                drem_reg <= dt[csim_pkg::DREM_W-1:0];
                q_reg    <= {q_reg[csim_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load) begin
            cos_reg  <= cos_val;
            zero_reg <= zero_val;
            long_reg <= ovf_reg;
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_cosine      = cos_reg;
    assign m_zero_norm   = zero_reg;
    assign m_too_long    = long_reg;

endmodule

[sv/cosine_similarity_unit.sv]
// top level of the streaming cosine similarity unit
// Usage:
//   Input beats carry one element pair (s_elem_a, s_elem_b, Q8.8) and
//   s_last_pair. Each beat is summed into the dot product and both sums of
//   squares, so pairs stream at one per cycle while the block is accumulating.
//   On the beat with s_last_pair high the block stops taking beats and runs
//   its back end: a shift-add multiply of the squared norms (41 steps), a
//   two-bit-per-step square root (42 steps), a restoring divide (56 steps),
//   each after a setup step. The result beat (m_cosine in Q2.14,
//   m_zero_norm, m_too_long) is loaded once the divide is done and the
//   output register is free; the input side is held until then.
//   The result sits in an output register; if the receiver still holds an
//   older result, the block waits with the new one until that beat is taken.
//   Pairs of the next vector are taken while a loaded result waits.
//   More than 1024 pairs are dropped from the sums and flag m_too_long.
//   Reset (aresetn low, synchronous) clears all sums and drops any result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cosine_similarity_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_elem_a,
    input  logic signed [15:0]  s_elem_b,
    input  logic                s_last_pair,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_cosine,
    output logic                m_zero_norm,
    output logic                m_too_long
);

    csim_pkg::cmd_t   cmd;
    csim_pkg::stat_t  stat;
    csim_pkg::state_t state;

    // sequencer
    csim_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_pair (s_last_pair),
        .s_ready     (s_ready),
        .stat        (stat),
        .cmd         (cmd),
        .state       (state)
    );

    // arithmetic
    csim_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_elem_a    (s_elem_a),
        .s_elem_b    (s_elem_b),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cosine    (m_cosine),
        .m_zero_norm (m_zero_norm),
        .m_too_long  (m_too_long)
    );

    // checks
    `CSIM_ASSERT_IMP(a_cos_range, aclk, aresetn, m_valid, (m_cosine <= 16'sd16384) && (m_cosine >= -16'sd16384), "cosine out of range")
    `CSIM_ASSERT_IMP(a_zero_cos, aclk, aresetn, m_valid && m_zero_norm, m_cosine == 16'sd0, "zero norm with nonzero cosine")
    `CSIM_ASSERT_NXT(a_busy_after_last, aclk, aresetn, s_valid && s_ready && s_last_pair, !s_ready && (state == csim_pkg::ST_MUL), "beat taken during back end")

endmodule

[verif/tb_top.sv]
// self-checking testbench for the streaming cosine similarity unit
`timescale 1ns / 1ps

module tb_top;

    localparam longint DOT_HI = (64'sd1 <<< (csim_pkg::DOT_W - 1)) - 1;
    localparam longint DOT_LO = -(64'sd1 <<< (csim_pkg::DOT_W - 1));
    localparam longint SQ_HI  = (64'sd1 <<< csim_pkg::SQ_W) - 1;

    typedef struct {
        logic signed [15:0] cosine;
        logic               zero_norm;
        logic               too_long;
    } cos_result_t;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
        bit                 typed;
        logic signed [15:0] cosine;
        logic               zero_norm;
        logic               too_long;
    } pair_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_elem_a;
    logic signed [15:0] s_elem_b;
    logic               s_last_pair;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_cosine;
    logic               m_zero_norm;
    logic               m_too_long;

    // predictor state
    longint          dot_acc;
    longint          sq_a_acc;
    longint          sq_b_acc;
    int              pairs_taken;
    bit              overflow_flag;
    cos_result_t     cosine_queue[$];

    int              error_count;
    int              tx_idle_pct;
    int              rx_idle_pct;

    cosine_similarity_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_elem_a    (s_elem_a),
        .s_elem_b    (s_elem_b),
        .s_last_pair (s_last_pair),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cosine    (m_cosine),
        .m_zero_norm (m_zero_norm),
        .m_too_long  (m_too_long)
    );

    // clock, 4 ns period
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic void clear_sums();
        dot_acc       = 0;
        sq_a_acc      = 0;
        sq_b_acc      = 0;
        pairs_taken   = 0;
        overflow_flag = 0;
    endfunction

    // floor square root of the product of the squared norms
    function automatic longint unsigned norm_root(longint unsigned x, longint unsigned y);
        logic [127:0] prod;
        logic [127:0] cand;
        logic [127:0] root;
        prod = 128'(x) * 128'(y);
        root = 0;
        for (int k = 42; k >= 0; k--) begin
            cand = root | (128'd1 << k);
            if (cand * cand <= prod)
                root = cand;
        end
        return root[63:0];
    endfunction

    // fold one pair into the sums; on the last pair return the cosine beat
    function automatic bit absorb_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                                       input logic last, output cos_result_t res);
        longint pa;
        longint pb;
        longint d;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        pa = a;
        pb = b;
        if (pairs_taken >= csim_pkg::MAX_ELEMENTS) begin
            overflow_flag = 1;
        end else begin
            d = dot_acc + pa * pb;
            if (d > DOT_HI) d = DOT_HI;
            if (d < DOT_LO) d = DOT_LO;
            dot_acc  = d;
            sq_a_acc = (sq_a_acc + pa * pa > SQ_HI) ? SQ_HI : sq_a_acc + pa * pa;
            sq_b_acc = (sq_b_acc + pb * pb > SQ_HI) ? SQ_HI : sq_b_acc + pb * pb;
            pairs_taken++;
        end
        if (!last)
            return 0;
        res.zero_norm = (sq_a_acc == 0) || (sq_b_acc == 0);
        res.too_long  = overflow_flag;
        res.cosine    = 0;
        if (!res.zero_norm) begin
            den = norm_root(sq_a_acc, sq_b_acc);
            if (den == 0) den = 1;
            mag = (dot_acc < 0) ? -dot_acc : dot_acc;
            q = (mag << 14) / den;
            if (q > csim_pkg::ONE_Q14) q = csim_pkg::ONE_Q14;
            res.cosine = (dot_acc < 0) ? -16'(q) : 16'(q);
        end
        clear_sums();
        return 1;
    endfunction

    // drive one beat, wait for it to be taken, then maybe leave a gap
    task automatic send_pair(input pair_row_t row);
        cos_result_t res;
        s_valid     <= 1'b1;
        s_elem_a    <= row.a;
        s_elem_b    <= row.b;
        s_last_pair <= row.last;
        do @(posedge aclk); while (!s_ready);
        if (absorb_pair(row.a, row.b, row.last, res)) begin
            if (row.typed) begin
                res.cosine    = row.cosine;
                res.zero_norm = row.zero_norm;
                res.too_long  = row.too_long;
            end
            cosine_queue.push_back(res);
        end
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    function automatic logic signed [15:0] pick_elem(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(15))) - 16'sd8;
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return '0;
        endcase
    endfunction

    // one vector pair of given length with random content
    task automatic send_vector(int len);
        pair_row_t row;
        int mode;
        int rel;
        mode = $urandom_range(3);
        rel  = $urandom_range(4);
        row.typed = 0;
        for (int i = 0; i < len; i++) begin
            row.a = pick_elem(mode);
            case (rel)
                0: row.b = row.a;
                1: row.b = -row.a;
                default: row.b = pick_elem($urandom_range(3));
            endcase
            if ($urandom_range(15) == 0) row.b = 0;
            row.last = (i == len - 1);
            send_pair(row);
        end
    endtask

    // result side: check each taken beat, then pick ready for the next edge
    always @(posedge aclk) begin
        cos_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cosine_queue.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = cosine_queue.pop_front();
                if (m_cosine !== want.cosine)
                    report_mismatch($sformatf("cosine %0d want %0d", m_cosine, want.cosine));
                if (m_zero_norm !== want.zero_norm)
                    report_mismatch($sformatf("zero_norm %0b want %0b",
                                              m_zero_norm, want.zero_norm));
                if (m_too_long !== want.too_long)
                    report_mismatch($sformatf("too_long %0b want %0b",
                                              m_too_long, want.too_long));
            end
        end
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // run limit
    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        pair_row_t dir_rows[$];
        int wait_cycles;

        error_count = 0;
        tx_idle_pct = 38;
        rx_idle_pct = 61;
        clear_sums();
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_elem_a    <= '0;
        s_elem_b    <= '0;
        s_last_pair <= 1'b0;
        m_ready     <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: a, b, last, typed, cosine, zero_norm, too_long
        dir_rows = '{
            '{16'sd0,      16'sd0,      1, 1, 16'sd0,      1, 0},
            '{16'sd0,      16'sd7,      1, 1, 16'sd0,      1, 0},
            '{16'sh8000,   16'sh8000,   1, 1, 16'sd16384,  0, 0},
            '{16'sd32767,  16'sd32767,  1, 1, 16'sd16384,  0, 0},
            '{16'sd1,      16'sd1,      1, 1, 16'sd16384,  0, 0},
            '{16'sd1,      -16'sd1,     1, 1, -16'sd16384, 0, 0},
            '{16'sh8000,   16'sd32767,  1, 0, 16'sd0,      0, 0},
            '{16'sd32767,  16'sh8000,   0, 0, 16'sd0,      0, 0},
            '{16'sh8000,   16'sd32767,  0, 0, 16'sd0,      0, 0},
            '{16'sd100,    -16'sd200,   1, 0, 16'sd0,      0, 0},
            '{16'sd256,    16'sd0,      0, 0, 16'sd0,      0, 0},
            '{16'sd0,      16'sd256,    1, 1, 16'sd0,      0, 0},
            '{16'sd0,      16'sd0,      0, 0, 16'sd0,      0, 0},
            '{16'sd0,      16'sd0,      0, 0, 16'sd0,      0, 0},
            '{16'sd5,      -16'sd3,     1, 0, 16'sd0,      0, 0},
            '{-16'sd1,     -16'sd1,     0, 0, 16'sd0,      0, 0},
            '{16'sd1,      16'sd1,      1, 1, 16'sd16384,  0, 0}
        };
        foreach (dir_rows[i])
            send_pair(dir_rows[i]);

        // random vectors over three idle phases, one long one to hit the element cap
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 61 : 0;
            rx_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 38 : 0;
            if (ph == 1) begin
                send_vector(csim_pkg::MAX_ELEMENTS + 1 + $urandom_range(6));
            end
            for (int n = 0; n < 160; ) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(1, 10);
                send_vector(len);
                n += len;
            end
        end
        s_valid <= 1'b0;

        // drain
        wait_cycles = 0;
        while (cosine_queue.size() != 0 && wait_cycles < 200_000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (300) @(posedge aclk);
        if (error_count == 0 && cosine_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[cosine_similarity_unit.f]
+incdir+sv
sv/csim_pkg.sv
sv/csim_ctrl.sv
sv/csim_dp.sv
sv/cosine_similarity_unit.sv
verif/tb_top.sv
